FILE: hdl/wucv_pkg.sv
// Shared constants and widths for the weather unit conversion pipeline.
package wucv_pkg;

    localparam int TEMP_W    = 12;   // tenths of a degree, signed
    localparam int TERM_W    = 32;   // e^x term, 20 fraction bits
    localparam int HORNER_N  = 7;    // order of the exponential series

    // Latency of the Tetens unit, input register to term register.
    // Two setup stages, eight divider stages, y and u stages,
    // three stages per series step, final shift.
    localparam int TET_LAT    = 2 + 8 + 1 + 1 + 3 * HORNER_N + 1;
    // Input stage, Tetens unit, five vapour stages.
    localparam int PIPE_DEPTH = 1 + TET_LAT + 5;

    // 2 * 17.27 * log2(e) * 2^24 * 100, scaled for tenths of a degree
    localparam logic [47:0] TWO_TETENS_C = 48'd83602019440;
    localparam logic [29:0] LN2_Q30      = 30'd744261118;
    localparam logic [31:0] ONE_Q30      = 32'h4000_0000;

    // Configuration register indexes
    localparam logic [1:0] CFG_RAIN_CAP = 2'd0;
    localparam logic [1:0] CFG_TMAX_CAP = 2'd1;
    localparam logic [1:0] CFG_RAD_CAP  = 2'd2;

endpackage

FILE: hdl/wucv_tetens.sv
// Pipelined Tetens exponential term e^(17.27 T / (237.3 + T)), 20 fraction bits.
module wucv_tetens (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [wucv_pkg::TEMP_W-1:0]  t,
    output logic [wucv_pkg::TERM_W-1:0]         term
);

    typedef struct packed {
        logic [19:0] rem;
        logic [31:0] quo;
    } div_t;

    // Four restoring division steps; quotient bits fill the low end.
    function automatic div_t div4(input logic [19:0] rem_in, input logic [31:0] quo_in,
                                  input logic [19:0] den);
        logic [20:0] r;
        logic [19:0] rm;
        logic [31:0] qo;
        div_t        res;
        rm = rem_in;
        qo = quo_in;
        for (int i = 0; i < 4; i++)
        begin
            r  = {rm, qo[31]};
            qo = {qo[30:0], 1'b0};
            if (r >= {1'b0, den})
            begin
                r     = r - {1'b0, den};
                qo[0] = 1'b1;
            end
            rm = r[19:0];
        end
        res.rem = rm;
        res.quo = qo;
        return res;
    endfunction

    localparam int DIV_ST = 8;
    localparam int HN_MAX = wucv_pkg::HORNER_N;

    // setup
    logic [11:0]        abs_t;
    logic signed [12:0] d_s;
    logic [47:0]        prod_reg;
    logic [18:0]        hund_reg;
    logic               neg1_reg;
    logic [47:0]        nabs;

    assign abs_t = t[11] ? 12'(-t) : 12'(t);
    assign d_s   = 13'sd2373 + 13'(t);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= wucv_pkg::TWO_TETENS_C * 48'(abs_t);
            hund_reg <= 19'(d_s[12:0]) * 19'd100;
            neg1_reg <= t[11];
        end
    end

    assign nabs = neg1_reg ? (prod_reg - 48'(hund_reg)) : (prod_reg + 48'(hund_reg));

    // divider
    logic [19:0] rem_reg [0:DIV_ST];
    logic [31:0] quo_reg [0:DIV_ST];
    logic [19:0] den_reg [0:DIV_ST];
    logic        dneg_reg[0:DIV_ST];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= 20'(nabs[47:32]);
            quo_reg[0]  <= nabs[31:0];
            den_reg[0]  <= {hund_reg, 1'b0};
            dneg_reg[0] <= neg1_reg;
        end
    end

    genvar gd;
    generate
        for (gd = 1; gd <= DIV_ST; gd++)
        begin : g_div
            div_t nxt;
            assign nxt = div4(rem_reg[gd-1], quo_reg[gd-1], den_reg[gd-1]);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[gd]  <= nxt.rem;
                    quo_reg[gd]  <= nxt.quo;
                    den_reg[gd]  <= den_reg[gd-1];
                    dneg_reg[gd] <= dneg_reg[gd-1];
                end
            end
        end
    endgenerate

    // floor quotient, split into integer and fraction of log2
    localparam logic [29:0] LN2_Q30_W = wucv_pkg::LN2_Q30;

    logic signed [33:0] y;
    logic signed [9:0]  k_reg;
    logic [23:0]        f_reg;
    logic [53:0]        fl_prod;
    logic [29:0]        u_reg;
    logic signed [9:0]  ku_reg;

    assign y = dneg_reg[DIV_ST]
             ? -(34'(quo_reg[DIV_ST]) + 34'(rem_reg[DIV_ST] != 20'd0))
             : 34'(quo_reg[DIV_ST]);
    assign fl_prod = 54'(f_reg) * 54'(LN2_Q30_W);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_reg  <= y[33:24];
            f_reg  <= y[23:0];
            u_reg  <= fl_prod[53:24];
            ku_reg <= k_reg;
        end
    end

    // series steps: fetch product, quotient by reciprocal or shift, correct
    logic [31:0]       v_a_reg [0:HN_MAX-1];
    logic [29:0]       u_a_reg [0:HN_MAX-1];
    logic signed [9:0] k_a_reg [0:HN_MAX-1];
    logic [31:0]       q_b_reg [0:HN_MAX-1];
    logic [31:0]       v_b_reg [0:HN_MAX-1];
    logic [29:0]       u_b_reg [0:HN_MAX-1];
    logic signed [9:0] k_b_reg [0:HN_MAX-1];
    logic [31:0]       p_c_reg [0:HN_MAX-1];
    logic [29:0]       u_c_reg [0:HN_MAX-1];
    logic signed [9:0] k_c_reg [0:HN_MAX-1];

    genvar g;
    generate
        for (g = 0; g < HN_MAX; g++)
        begin : g_step
            localparam int HN = HN_MAX - g;
            logic [29:0]       u_in;
            logic signed [9:0] k_in;
            logic [31:0]       p_in;
            logic [61:0]       up_prod;
            logic [31:0]       q0;
            logic [31:0]       rem_c;
            logic [31:0]       p_next;

            if (g == 0)
            begin : g_first
                assign u_in = u_reg;
                assign k_in = ku_reg;
                assign p_in = wucv_pkg::ONE_Q30;
            end
            else
            begin : g_later
                assign u_in = u_c_reg[g-1];
                assign k_in = k_c_reg[g-1];
                assign p_in = p_c_reg[g-1];
            end

            assign up_prod = 62'(u_in) * 62'(p_in);

            if ((HN & (HN - 1)) == 0)
            begin : g_pow2
                localparam int LG = $clog2(HN);
                assign q0 = v_a_reg[g] >> LG;
            end
            else
            begin : g_recip
                localparam logic [29:0] RECIP = 30'((64'd1 << 31) / HN);
                logic [61:0] rq_prod;
                assign rq_prod = 62'(v_a_reg[g]) * 62'(RECIP);
                assign q0      = 32'(rq_prod[61:31]);
            end

            // estimate may sit one below the true quotient
            assign rem_c  = v_b_reg[g] - 32'(HN) * q_b_reg[g];
            assign p_next = wucv_pkg::ONE_Q30 + q_b_reg[g] + 32'(rem_c >= 32'(HN));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    v_a_reg[g] <= up_prod[61:30];
                    u_a_reg[g] <= u_in;
                    k_a_reg[g] <= k_in;
                    q_b_reg[g] <= q0;
                    v_b_reg[g] <= v_a_reg[g];
                    u_b_reg[g] <= u_a_reg[g];
                    k_b_reg[g] <= k_a_reg[g];
                    p_c_reg[g] <= p_next;
                    u_c_reg[g] <= u_b_reg[g];
                    k_c_reg[g] <= k_b_reg[g];
                end
            end
        end
    endgenerate

    // scale by 2^(k-10); k never exceeds 11 over the saturated temperature range
    logic signed [10:0] sh;
    logic signed [10:0] nsh;
    logic [31:0]        p_fin;
    logic [31:0]        term_next;
    logic [31:0]        term_reg;

    assign p_fin = p_c_reg[HN_MAX-1];
    assign sh    = 11'(k_c_reg[HN_MAX-1]) - 11'sd10;
    assign nsh   = -sh;

    always_comb
    begin
        if (sh >= 11'sd0)
            term_next = p_fin << sh[0];
        else if (nsh >= 11'sd32)
            term_next = 32'd0;
        else
            term_next = p_fin >> nsh[4:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            term_reg <= term_next;
    end

    assign term = term_reg;

endmodule

FILE: hdl/weather_unit_convert_vapour.sv
// Top level: climate unit conversion with Tetens vapour pressure.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid/in_ready   | rain_flux tmax_kelvin tmin_kelvin wind_speed
//          |                     | shortwave_flux humidity_pct
//  out     | out_valid/out_ready | rain_out tmax_out tmin_out wind_out
//          |                     | radiation_out vapour_out
//  cfg     | cfg_valid/cfg_ready | cfg_index cfg_data (always ready)
//
// One beat a cycle sustained while the skid register is free; the pipeline depth
// is set by the 32-bit restoring divider and the seven-step series chain in the
// Tetens units. Reset clears the stage valids, the output buffer and the caps to
// their defaults. When the sink stalls, the output register holds one result and
// a skid register takes the next; only when the skid is full does the whole
// pipeline hold.
module weather_unit_convert_vapour (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [36:0]         rain_flux,
    input  logic [16:0]         tmax_kelvin,
    input  logic [16:0]         tmin_kelvin,
    input  logic [14:0]         wind_speed,
    input  logic [18:0]         shortwave_flux,
    input  logic [14:0]         humidity_pct,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         rain_out,
    output logic signed [11:0]  tmax_out,
    output logic signed [11:0]  tmin_out,
    output logic [9:0]          wind_out,
    output logic [25:0]         radiation_out,
    output logic [15:0]         vapour_out,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [25:0]         cfg_data
);

    localparam int DEPTH    = wucv_pkg::PIPE_DEPTH;
    localparam int SIDE_LEN = DEPTH - 1;
    // side line index holding the beat that sits in the esum stage
    localparam int HUM_TAP  = wucv_pkg::TET_LAT;

    typedef struct packed {
        logic [15:0]        rain;
        logic signed [11:0] tmax;
        logic signed [11:0] tmin;
        logic [9:0]         wind;
        logic [25:0]        rad;
        logic [27:0]        hum;
    } side_t;

    typedef struct packed {
        logic [15:0]        rain;
        logic signed [11:0] tmax;
        logic signed [11:0] tmin;
        logic [9:0]         wind;
        logic [25:0]        rad;
        logic [15:0]        vap;
    } res_t;

    // Kelvin with 8 fraction bits to rounded tenths of a degree, saturated
    function automatic logic signed [11:0] to_tenths(input logic [16:0] k);
        logic [20:0]        k10;
        logic signed [22:0] n;
        logic signed [14:0] t;
        k10 = 21'(k) * 21'd10;
        n   = $signed({2'b00, k10}) - 23'sd699136;
        t   = 15'(n >>> 8);
        if (t > 15'sd2047)
            return 12'sd2047;
        else if (t < -15'sd2048)
            return -12'sd2048;
        return 12'(t);
    endfunction

    // configuration
    logic [15:0]        rain_cap_reg;
    logic signed [11:0] tmax_cap_reg;
    logic [25:0]        rad_cap_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rain_cap_reg <= 16'd24950;
            tmax_cap_reg <= 12'sd500;
            rad_cap_reg  <= 26'd39999999;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                wucv_pkg::CFG_RAIN_CAP: rain_cap_reg <= cfg_data[15:0];
                wucv_pkg::CFG_TMAX_CAP: tmax_cap_reg <= cfg_data[11:0];
                wucv_pkg::CFG_RAD_CAP:  rad_cap_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // advance whenever the skid register is free
    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;
    logic [DEPTH-1:0] valid_reg;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
    end

    // stage A: scale inputs
    logic [56:0]        rain_prod_a_reg;
    logic signed [11:0] tmax_a_reg;
    logic signed [11:0] tmin_a_reg;
    logic [9:0]         wind_a_reg;
    logic [20:0]        rad_a_reg;
    logic [27:0]        hum_a_reg;
    logic [18:0]        w10;
    logic [28:0]        s864;

    assign w10  = 19'(wind_speed) * 19'd10 + 19'd128;
    assign s864 = 29'(shortwave_flux) * 29'd864 + 29'd128;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rain_prod_a_reg <= 57'(rain_flux) * 57'd864000;
            tmax_a_reg      <= to_tenths(tmax_kelvin);
            tmin_a_reg      <= to_tenths(tmin_kelvin);
            wind_a_reg      <= (w10[18:8] > 11'd1023) ? 10'd1023 : w10[17:8];
            rad_a_reg       <= s864[28:8];
            hum_a_reg       <= 28'(humidity_pct) * 28'd6108;
        end
    end

    // stage B: round and clamp, then delay alongside the vapour path
    logic [56:0] rain_sum;
    logic [16:0] rain17;
    logic [27:0] rad28;
    side_t       side_b;
    side_t       side_reg [0:SIDE_LEN-1];

    assign rain_sum = rain_prod_a_reg + (57'd1 << 39);
    assign rain17   = rain_sum[56:40];
    assign rad28    = 28'(rad_a_reg) * 28'd100;

    always_comb
    begin
        side_b.rain = (rain17 > {1'b0, rain_cap_reg}) ? rain_cap_reg : rain17[15:0];
        side_b.tmax = (tmax_a_reg > tmax_cap_reg) ? tmax_cap_reg : tmax_a_reg;
        side_b.tmin = tmin_a_reg;
        side_b.wind = wind_a_reg;
        side_b.rad  = (rad28 > {2'b00, rad_cap_reg}) ? rad_cap_reg : rad28[25:0];
        side_b.hum  = hum_a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_b;
            for (int i = 1; i < SIDE_LEN; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // saturation pressure terms, unclamped Tmax and Tmin
    logic [wucv_pkg::TERM_W-1:0] term_max;
    logic [wucv_pkg::TERM_W-1:0] term_min;

    wucv_tetens u_tetens_max (
        .clk  (clk),
        .en   (en),
        .t    (tmax_a_reg),
        .term (term_max)
    );

    wucv_tetens u_tetens_min (
        .clk  (clk),
        .en   (en),
        .t    (tmin_a_reg),
        .term (term_min)
    );

    // vapour: round(hum * 6108 * esum / (125 * 2^32)), saturated
    logic [32:0] esum_reg;
    logic [60:0] x_reg;
    logic [61:0] x_sum;
    logic [29:0] z_reg;
    logic [59:0] zq_prod;
    logic [23:0] q0_reg;
    logic [29:0] z4_reg;
    logic [29:0] z_rem;
    logic [23:0] vq;
    logic [15:0] vap_reg;

    localparam logic [29:0] RECIP_125 = 30'((64'd1 << 36) / 125);

    assign x_sum   = 62'(x_reg) + 62'd268435456000;
    assign zq_prod = 60'(z_reg) * 60'(RECIP_125);
    // estimate may sit one below the true quotient
    assign z_rem   = z4_reg - 30'(q0_reg) * 30'd125;
    assign vq      = q0_reg + 24'(z_rem >= 30'd125);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            esum_reg <= 33'(term_max) + 33'(term_min);
            x_reg    <= 61'(side_reg[HUM_TAP].hum) * 61'(esum_reg);
            z_reg    <= x_sum[61:32];
            q0_reg   <= zq_prod[59:36];
            z4_reg   <= z_reg;
            vap_reg  <= (vq > 24'd65535) ? 16'hFFFF : vq[15:0];
        end
    end

    // output register plus skid
    res_t last;
    res_t main_reg;
    res_t skid_reg;
    logic push;
    logic pop;

    always_comb
    begin
        last.rain = side_reg[SIDE_LEN-1].rain;
        last.tmax = side_reg[SIDE_LEN-1].tmax;
        last.tmin = side_reg[SIDE_LEN-1].tmin;
        last.wind = side_reg[SIDE_LEN-1].wind;
        last.rad  = side_reg[SIDE_LEN-1].rad;
        last.vap  = vap_reg;
    end

    assign push = en & valid_reg[DEPTH-1];
    assign pop  = out_valid_reg & out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_reg <= last;
            else
                main_reg <= last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign rain_out      = main_reg.rain;
    assign tmax_out      = main_reg.tmax;
    assign tmin_out      = main_reg.tmin;
    assign wind_out      = main_reg.wind;
    assign radiation_out = main_reg.rad;
    assign vapour_out    = main_reg.vap;

endmodule

FILE: tb/tb_weather_unit_convert_vapour.sv
// Self-checking testbench for the climate unit conversion and Tetens vapour pipeline.
module tb_weather_unit_convert_vapour;

    // Result fields of one beat, as the block presents them.
    typedef struct packed {
        logic [15:0]        rain;
        logic signed [11:0] tmax;
        logic signed [11:0] tmin;
        logic [9:0]         wind;
        logic [25:0]        rad;
        logic [15:0]        vap;
    } conv_res_t;

    // Convert Kelvin (8 fraction bits) to saturated tenths of a degree.
    function automatic longint kelvin_tenths(logic [16:0] k);
        longint n;
        longint t;
        n = longint'(k) * 10 - 699264 + 128;
        t = (n >= 0) ? n / 256 : -((-n + 255) / 256);
        if (t > 2047) t = 2047;
        if (t < -2048) t = -2048;
        return t;
    endfunction

    function automatic longint fdiv(longint n, longint d);
        return (n >= 0) ? n / d : -((-n + d - 1) / d);
    endfunction

    // e^(17.27 T / (237.3 + T)) with 20 fraction bits.
    function automatic longint unsigned tetens_term(longint t);
        longint d;
        longint y;
        longint k;
        longint sh;
        longint unsigned f;
        longint unsigned u;
        longint unsigned p;
        d = 2373 + t;
        y = fdiv(2 * 64'sd41801009720 * t + 100 * d, 200 * d);
        k = fdiv(y, 64'sd16777216);
        f = longint'(y - k * 64'sd16777216);
        u = (f * 64'd744261118) >> 24;
        p = 64'd1 << 30;
        for (int n = 7; n >= 1; n--)
            p = (64'd1 << 30) + ((u * p) >> 30) / n;
        sh = k - 10;
        if (sh >= 0)
        begin
            if (sh > 16) sh = 16;
            return p << sh;
        end
        if (-sh >= 63) return 0;
        return p >> (-sh);
    endfunction

    class conv_scoreboard;
        conv_res_t        pending[$];
        longint unsigned  rain_cap;
        longint           tmax_cap;
        longint unsigned  rad_cap;
        int               errors;

        function new();
            rain_cap = 24950;
            tmax_cap = 500;
            rad_cap  = 39999999;
            errors   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [25:0] v);
            if (idx == wucv_pkg::CFG_RAIN_CAP) rain_cap = v[15:0];
            else if (idx == wucv_pkg::CFG_TMAX_CAP) tmax_cap = longint'($signed(v[11:0]));
            else if (idx == wucv_pkg::CFG_RAD_CAP) rad_cap = v;
        endfunction

        // Work out the expected result of one accepted input beat.
        function void note_input(logic [36:0] rf, logic [16:0] tx, logic [16:0] tn,
                                 logic [14:0] ws, logic [18:0] sw, logic [14:0] hu);
            longint unsigned rain;
            longint unsigned wind;
            longint unsigned rad;
            longint unsigned esum;
            longint unsigned vap;
            longint          tmx;
            longint          tmn;
            conv_res_t       r;
            // 37 bits times 864000 fits in 64 bits
            rain = (longint'(rf) * 64'd864000 + (64'd1 << 39)) >> 40;
            tmx  = kelvin_tenths(tx);
            tmn  = kelvin_tenths(tn);
            wind = (longint'(ws) * 10 + 128) >> 8;
            rad  = 100 * ((longint'(sw) * 864 + 128) >> 8);
            esum = tetens_term(tmx) + tetens_term(tmn);
            vap  = (longint'(hu) * 6108 * esum + ((64'd512000 << 20) / 2))
                   / (64'd512000 << 20);
            if (rain > rain_cap) rain = rain_cap;
            if (wind > 1023) wind = 1023;
            if (rad > rad_cap) rad = rad_cap;
            if (vap > 65535) vap = 65535;
            if (tmx > tmax_cap) tmx = tmax_cap;
            r.rain = rain[15:0];
            r.tmax = tmx[11:0];
            r.tmin = tmn[11:0];
            r.wind = wind[9:0];
            r.rad  = rad[25:0];
            r.vap  = vap[15:0];
            pending.push_back(r);
        endfunction

        function void check_result(conv_res_t got);
            conv_res_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.rain !== e.rain)
                begin $display("%0t: rain exp %0d got %0d", $time, e.rain, got.rain); errors++; end
            if (got.tmax !== e.tmax)
                begin $display("%0t: tmax exp %0d got %0d", $time, e.tmax, got.tmax); errors++; end
            if (got.tmin !== e.tmin)
                begin $display("%0t: tmin exp %0d got %0d", $time, e.tmin, got.tmin); errors++; end
            if (got.wind !== e.wind)
                begin $display("%0t: wind exp %0d got %0d", $time, e.wind, got.wind); errors++; end
            if (got.rad !== e.rad)
                begin $display("%0t: rad exp %0d got %0d", $time, e.rad, got.rad); errors++; end
            if (got.vap !== e.vap)
                begin $display("%0t: vapour exp %0d got %0d", $time, e.vap, got.vap); errors++; end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [36:0]        rain_flux = '0;
    logic [16:0]        tmax_kelvin = 17'd70000;
    logic [16:0]        tmin_kelvin = 17'd70000;
    logic [14:0]        wind_speed = '0;
    logic [18:0]        shortwave_flux = '0;
    logic [14:0]        humidity_pct = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [15:0]        rain_out;
    logic signed [11:0] tmax_out;
    logic signed [11:0] tmin_out;
    logic [9:0]         wind_out;
    logic [25:0]        radiation_out;
    logic [15:0]        vapour_out;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [25:0]        cfg_data = '0;

    conv_scoreboard sb = new();
    bit  quiet_phase;          // no random idling on either side
    int  sink_hold;            // cycles left in a forced sink stall

    weather_unit_convert_vapour uut (.*);

    always #1 clk = ~clk;

    // Watch both channels at the rising edge: note inputs, check results.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_input(rain_flux, tmax_kelvin, tmin_kelvin, wind_speed,
                          shortwave_flux, humidity_pct);
        if (rst_n && out_valid && out_ready)
            sb.check_result({rain_out, tmax_out, tmin_out, wind_out,
                             radiation_out, vapour_out});
    end

    // Sink: random stalls, a quiet stretch, and forced long holds.
    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 10);
    end

    // Offer one input beat and hold it until accepted; drop valid only while idling.
    task automatic send_item(logic [36:0] rf, logic [16:0] tx, logic [16:0] tn,
                             logic [14:0] ws, logic [18:0] sw, logic [14:0] hu);
        while (!quiet_phase && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        rain_flux      <= rf;
        tmax_kelvin    <= tx;
        tmin_kelvin    <= tn;
        wind_speed     <= ws;
        shortwave_flux <= sw;
        humidity_pct   <= hu;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        logic [36:0] rf;
        logic [16:0] tx;
        logic [16:0] tn;
        rf = 37'({$urandom, $urandom}) & ((37'd1 << $urandom_range(37, 20)) - 1);
        tx = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(89600, 38400));
        tn = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(89600, 38400));
        send_item(rf, tx, tn, 15'($urandom), 19'($urandom), 15'($urandom));
    endtask

    // Drop valid, then wait until every expected result has arrived, plus the depth.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (wucv_pkg::PIPE_DEPTH + 4) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [25:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, v);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        #2000000;
        $display("weather_unit_convert_vapour: mismatch");
        $finish;
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes of every field, saturating temperatures.
        send_item('0, 17'd38400, 17'd38400, '0, '0, '0);
        send_item(37'h1F_FFFF_FFFF, 17'd89600, 17'd89600, 15'd25600, 19'd384000, 15'd28160);
        send_item(37'h1F_FFFF_FFFF, 17'h1FFFF, 17'h1FFFF, 15'h7FFF, 19'h7FFFF, 15'h7FFF);
        send_item('0, '0, '0, '0, '0, 15'h7FFF);
        send_item(37'd1 << 36, 17'd69926, 17'd69926, 15'd128, 19'd128, 15'd25600);
        send_item(37'd318, 17'd75000, 17'd65000, 15'd1, 19'd1, 15'd12800);
        send_item(37'd1 << 30, 17'd71000, 17'd60000, 15'd300, 19'd51200, 15'd20000);
        drain();

        // Extreme cap settings, then the upper ends.
        write_reg(wucv_pkg::CFG_RAIN_CAP, 26'd0);
        write_reg(wucv_pkg::CFG_TMAX_CAP, 26'hFFB30);  // -1232 in 12 bits
        write_reg(wucv_pkg::CFG_RAD_CAP, 26'd0);
        write_reg(2'd3, 26'h3FFFFFF);       // unused index, ignored
        for (int i = 0; i < 8; i++) send_random();
        drain();
        write_reg(wucv_pkg::CFG_RAIN_CAP, 26'hFFFF);
        write_reg(wucv_pkg::CFG_TMAX_CAP, 26'd769);
        write_reg(wucv_pkg::CFG_RAD_CAP, 26'h3FFFFFF);
        for (int i = 0; i < 8; i++) send_random();
        drain();

        // Random phases, each under a new random cap setting.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(wucv_pkg::CFG_RAIN_CAP, 26'($urandom));
            write_reg(wucv_pkg::CFG_TMAX_CAP, 26'($urandom));
            write_reg(wucv_pkg::CFG_RAD_CAP, 26'($urandom));
            quiet_phase = (ph == 2);
            if (ph == 3)
                sink_hold = 200;  // force the pipeline and skid to fill
            for (int i = 0; i < 310; i++) send_random();
            drain();               // sender pauses until all results are in
        end
        quiet_phase = 1'b0;
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("weather_unit_convert_vapour: match");
        else
            $display("weather_unit_convert_vapour: mismatch");
        $finish;
    end
endmodule
